@@ rtl/segment_descriptor_table_unit_macros.svh @@
// Assertion macros for the segment descriptor table unit.
`ifndef SEGMENT_DESCRIPTOR_TABLE_UNIT_MACROS_SVH
`define SEGMENT_DESCRIPTOR_TABLE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SDT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check on the unit's own clock and reset.
`define SDT_CHECK(label, prop, msg) \
  `SDT_ASSERT(label, clk_i, rst_ni, prop, msg)
`endif

@@ rtl/sdt_pkg.sv @@
// Shared types and constants for the segment descriptor table unit.
package sdt_pkg;
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned FrameBytesDef   = 8;

  typedef enum logic [1:0] {
    MODE_REGISTER  = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_LOOKUP    = 2'd2,
    MODE_FARRET    = 2'd3
  } mode_e;
endpackage

@@ rtl/segment_descriptor_table_unit.sv @@
// Segment descriptor table: register, translate, reverse lookup and far return.
// One request at a time. A request that is not turned away at acceptance
// scans the descriptor table one entry a cycle with a single shared entry
// comparator, then translate and far return run the range checks in the
// CHECK and CHECK2 states on a shared 33-bit adder/compare step before the
// result is registered. A far return can scan the table twice, first for
// its own selector and then for the target. A result is held until
// out_ready_i takes it. The table is empty after reset; entries above
// the fill count are never read, so no clearing pass is needed.
// in_ready_o is low while a request is in work or its result waits to be taken.
module segment_descriptor_table_unit
  import sdt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned FRAME_BYTES   = FrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] selector_i,
  input  logic [31:0] base_i,
  input  logic [31:0] limit_i,
  input  logic        present_i,
  input  logic        executable_i,
  input  logic        code16_i,
  input  logic [31:0] offset_i,
  input  logic [31:0] access_len_i,
  input  logic [31:0] lookup_address_i,
  input  logic [31:0] selector_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic        replaced_o,
  output logic        table_full_o,
  output logic [31:0] linear_out_o,
  output logic [15:0] selector_out_o,
  output logic [31:0] target_offset_out_o,
  output logic [7:0]  pop_bytes_o
);
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CHECK, ST_CHECK2, ST_DONE
  } state_e;

  // descriptor storage, written at one place, read at the scan index
  logic [15:0] sel_mem [TABLE_ENTRIES];
  logic [31:0] base_mem [TABLE_ENTRIES];
  logic [31:0] lim_mem [TABLE_ENTRIES];
  logic [2:0]  flg_mem [TABLE_ENTRIES];

  state_e      state_q;
  logic [CW-1:0] count_q, idx_q;
  logic [1:0]  mode_q;
  logic [15:0] sel_q, tsel_q;
  logic [31:0] base_q, lim_q, off_q, cnt_q, addr_q;
  logic [2:0]  flg_q;
  logic        pass2_q;          // far return: scanning for the target
  logic        hit_q;
  logic [15:0] hsel_q;
  logic [31:0] hbase_q, hlim_q;
  logic [32:0] win_end_q;        // base + limit of the hit, 33 bits

  logic        ok_q, rep_q, full_q;
  logic [31:0] lin_q, toff_q;
  logic [15:0] osel_q;
  logic [7:0]  sb_q;

  // shared scan comparator on the entry at idx
  logic [IW-1:0] ix;
  logic [15:0] e_sel;
  logic [31:0] e_base, e_lim;
  logic [2:0]  e_flg;
  logic [15:0] key;
  logic        scan_end, e_match;
  logic [32:0] e_end;
  assign ix     = idx_q[IW-1:0];
  assign e_sel  = sel_mem[ix];
  assign e_base = base_mem[ix];
  assign e_lim  = lim_mem[ix];
  assign e_flg  = flg_mem[ix];
  assign key    = pass2_q ? tsel_q : sel_q;
  assign scan_end = (idx_q >= count_q);
  assign e_end  = {1'b0, e_base} + {1'b0, e_lim};
  always_comb begin
    unique case (mode_q)
      MODE_REGISTER: e_match = (e_sel == key);
      MODE_LOOKUP:   e_match = e_flg[0] && (addr_q >= e_base) &&
                               ({1'b0, addr_q} <= e_end);
      default:       e_match = (e_sel == key) && e_flg[0];
    endcase
  end

  // shared 33-bit adder for the range checks
  logic [32:0] add_a, add_b, add_s;
  logic [31:0] len_m1;
  assign len_m1 = cnt_q - 32'd1;
  always_comb begin
    if (state_q == ST_CHECK) begin
      add_a = {1'b0, off_q};   add_b = {1'b0, len_m1};      // last offset
    end else begin
      add_a = {1'b0, hbase_q}; add_b = {1'b0, off_q};       // linear address
    end
  end
  assign add_s = add_a + add_b;
  // linear + len - 1 fits iff linear <= MAX - (len - 1)
  logic [32:0] lin_room;
  assign lin_room = {1'b0, ~len_m1};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign ok_o = ok_q;  assign replaced_o = rep_q;  assign table_full_o = full_q;
  assign linear_out_o = lin_q;  assign selector_out_o = osel_q;
  assign target_offset_out_o = toff_q;  assign pop_bytes_o = sb_q;

  logic        wr_en;
  logic [IW-1:0] wr_ix;
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sel_mem[wr_ix]  <= sel_q;
      base_mem[wr_ix] <= base_q;
      lim_mem[wr_ix]  <= lim_q;
      flg_mem[wr_ix]  <= flg_q;
    end
  end

  // register: overwrite the matching entry, or append at the fill count
  logic last_bad_q;
  always_comb begin
    wr_ix = scan_end ? count_q[IW-1:0] : ix;
    wr_en = (state_q == ST_SCAN) && (mode_q == MODE_REGISTER) &&
            (scan_end ? (count_q < CW'(TABLE_ENTRIES)) : e_match);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pass2_q <= 1'b0;
      mode_q  <= MODE_REGISTER;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (in_valid_i) begin
          mode_q <= mode_i;   sel_q <= selector_i;  base_q <= base_i;
          lim_q <= limit_i;   flg_q <= {code16_i, executable_i, present_i};
          off_q <= offset_i;  cnt_q <= access_len_i; addr_q <= lookup_address_i;
          tsel_q <= selector_slot_i[15:0];
          idx_q <= '0;  hit_q <= 1'b0;  pass2_q <= 1'b0;
          ok_q <= 1'b0; rep_q <= 1'b0; full_q <= 1'b0;
          lin_q <= '0;  osel_q <= '0;  toff_q <= '0;  sb_q <= '0;
          // selector zero never finds or registers anything
          if (mode_i != MODE_LOOKUP && selector_i == 16'd0) state_q <= ST_DONE;
          else if (mode_i == MODE_TRANSLATE && access_len_i == 32'd0)
            state_q <= ST_DONE;
          else state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (mode_q == MODE_REGISTER) begin
            if (e_match && !scan_end) begin
              ok_q <= 1'b1; rep_q <= 1'b1; state_q <= ST_DONE;
            end else if (scan_end) begin
              if (count_q < CW'(TABLE_ENTRIES)) begin
                ok_q <= 1'b1; count_q <= count_q + CW'(1);
              end else full_q <= 1'b1;
              state_q <= ST_DONE;
            end else idx_q <= idx_q + CW'(1);
          end else if (mode_q == MODE_LOOKUP) begin
            if (scan_end) begin
              ok_q <= hit_q;  osel_q <= hit_q ? hsel_q : 16'd0;
              state_q <= ST_DONE;
            end else if (e_match && hit_q) begin
              state_q <= ST_DONE;       // ambiguous
            end else begin
              if (e_match) begin hit_q <= 1'b1; hsel_q <= e_sel; end
              idx_q <= idx_q + CW'(1);
            end
          end else begin
            if (scan_end) state_q <= ST_DONE;        // not found
            else if (e_match) begin
              hbase_q <= e_base; hlim_q <= e_lim;
              win_end_q <= e_end; hit_q <= 1'b1;
              if (mode_q == MODE_FARRET && !pass2_q) begin
                if (e_flg[1] && e_flg[2] && tsel_q != 16'd0) begin
                  pass2_q <= 1'b1; idx_q <= '0;
                end else state_q <= ST_DONE;
              end else if (mode_q == MODE_FARRET && !e_flg[1]) begin
                state_q <= ST_DONE;
              end else begin
                if (mode_q == MODE_FARRET) cnt_q <= 32'd1;
                state_q <= ST_CHECK;
              end
            end else idx_q <= idx_q + CW'(1);
          end
        end
        ST_CHECK: begin
          last_bad_q <= add_s > {1'b0, hlim_q};
          state_q <= ST_CHECK2;
        end
        ST_CHECK2: begin
          if (!last_bad_q && !add_s[32] && add_s <= lin_room) begin
            ok_q <= 1'b1; lin_q <= add_s[31:0];
          end else if (mode_q == MODE_FARRET && off_q >= hbase_q &&
                       {1'b0, off_q} <= win_end_q) begin
            ok_q <= 1'b1; lin_q <= off_q;
          end
          if (mode_q == MODE_FARRET) begin
            if ((!last_bad_q && !add_s[32] && add_s <= lin_room) ||
                (off_q >= hbase_q && {1'b0, off_q} <= win_end_q)) begin
              osel_q <= tsel_q; toff_q <= off_q; sb_q <= 8'(FRAME_BYTES);
            end
          end
          state_q <= ST_DONE;
        end
        ST_DONE: if (out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/sdt_checker.sv @@
// Port-level assertions for the segment descriptor table unit.
`include "segment_descriptor_table_unit_macros.svh"
module sdt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       ok_o,
  input logic       replaced_o,
  input logic       table_full_o,
  input logic [7:0] pop_bytes_o
);
  // one request in flight: never ready while a result is shown
  `SDT_CHECK(a_excl, out_valid_o |-> !in_ready_o, "ready with result")
  // an accepted request blocks the input next cycle
  `SDT_CHECK(a_busy, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  // failure flags only without success
  `SDT_CHECK(a_full, (out_valid_o && table_full_o) |-> !ok_o && !replaced_o, "full with ok")
  `SDT_CHECK(a_rep, (out_valid_o && !ok_o) |-> !replaced_o && pop_bytes_o == 8'd0,
             "fields on fail")
  // a waiting result holds
  `SDT_CHECK(a_hold, (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(ok_o),
             "result dropped")
endmodule

bind segment_descriptor_table_unit sdt_checker u_sdt_checker (.*);
